// ===== hdl/int32_decimal_text_formatter_unit_defines.svh =====
// Assertion macros shared by the formatter RTL.
// No dependencies; include with the bare file name inside a module body.
`ifndef INT32_DECIMAL_TEXT_FORMATTER_UNIT_DEFINES_SVH
`define INT32_DECIMAL_TEXT_FORMATTER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define I32FMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define I32FMT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/i32fmt_pkg.sv =====
// Shared widths, ASCII codes and types for the decimal text formatter.
// No dependencies.
`timescale 1ns / 1ps

package i32fmt_pkg;

  localparam int BIN_W     = 32;  // input value width
  localparam int CHAR_W    = 8;
  localparam int NDIG      = 10;  // decimal digits of a 32-bit magnitude
  localparam int BCD_W     = 4 * NDIG;
  localparam int CNT_W     = 4;   // holds 0..NDIG
  localparam int NSTG      = 4;   // shift-add-3 stages
  localparam int STG_STEPS = BIN_W / NSTG;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef logic [NDIG-1:0][3:0] bcd_t;

  // one pipeline slot: sign, separator flag, BCD digits and remaining binary bits
  typedef struct packed {
    logic              neg;
    logic              sep;
    bcd_t              bcd;
    logic [BIN_W-1:0]  bin;
  } stg_t;

endpackage

// ===== hdl/i32fmt_in_if.sv =====
// Input channel: one signed 32-bit value and its separator flag per beat.
// Depends on i32fmt_pkg.
`timescale 1ns / 1ps

interface i32fmt_in_if;
  import i32fmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [BIN_W-1:0]  value;
  logic              separator_follows;

  modport source (output valid, value, separator_follows, input ready);
  modport sink   (input valid, value, separator_follows, output ready);
endinterface

// ===== hdl/i32fmt_out_if.sv =====
// Output channel: one ASCII character and its end-of-run flag per beat.
// Depends on i32fmt_pkg.
`timescale 1ns / 1ps

interface i32fmt_out_if;
  import i32fmt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface

// ===== hdl/int32_decimal_text_formatter_unit.sv =====
// Channel  Dir  Beat contents
// din      in   value[31:0] signed, separator_follows
// dout     out  character[7:0] ASCII, last_char
//
// An accepted value passes a capture stage and four shift-add-3 stages (8 bits
// each), then loads the character emitter. The emitter sends one character per
// cycle while dout is not stalled, 1 to 12 per value, and loads no new value
// until the last one is sent; that emitter sets the sustained rate.
// rst is synchronous and clears all valid bits. A stall on dout holds the
// output register and backs up through the stages without loss.
// Depends on i32fmt_pkg, i32fmt_in_if, i32fmt_out_if and the defines header.
`timescale 1ns / 1ps

module int32_decimal_text_formatter_unit (
  input  logic   clk,
  input  logic   rst,
  i32fmt_in_if.sink    din,
  i32fmt_out_if.source dout
);
  import i32fmt_pkg::*;
  `include "int32_decimal_text_formatter_unit_defines.svh"

  // ---------------- conversion pipeline ----------------
  logic  v   [0:NSTG];
  stg_t  stg [0:NSTG];
  stg_t  stg_d [0:NSTG];
  logic  adv [0:NSTG];
  logic  load;

  function automatic stg_t dabble(input stg_t x);
    stg_t y;
    y = x;
    for (int s = 0; s < STG_STEPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (y.bcd[d] >= 4'd5) y.bcd[d] = y.bcd[d] + 4'd3;
      end
      {y.bcd, y.bin} = {y.bcd, y.bin} << 1;
    end
    return y;
  endfunction

  always_comb begin
    stg_d[0].neg = din.value[BIN_W-1];
    stg_d[0].sep = din.separator_follows;
    stg_d[0].bcd = '0;
    // most negative value maps to itself as unsigned 2^31
    stg_d[0].bin = din.value[BIN_W-1] ? (~din.value + 1'b1) : din.value;
    for (int k = 1; k <= NSTG; k++) begin
      stg_d[k] = dabble(stg[k-1]);
    end
  end

  always_comb begin
    adv[NSTG] = !v[NSTG] || load;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign din.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NSTG; k++) v[k] <= 1'b0;
    end else begin
      if (adv[0]) v[0] <= din.valid;
      for (int k = 1; k <= NSTG; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NSTG; k++) begin
      if (adv[k]) stg[k] <= stg_d[k];
    end
  end

  // ---------------- character emitter ----------------
  logic              busy;
  logic              sign_p;
  logic              space_p;
  logic [CNT_W-1:0]  dig_left;
  bcd_t              digits;
  logic [CNT_W-1:0]  ndig_d;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic [CNT_W-1:0]  dig_idx;

  always_comb begin
    ndig_d = CNT_W'(1);
    for (int d = 1; d < NDIG; d++) begin
      if (stg[NSTG].bcd[d] != 4'd0) ndig_d = CNT_W'(d + 1);
    end
  end

  assign busy    = sign_p || space_p || (dig_left != '0);
  assign load    = !busy && v[NSTG];
  assign emit    = busy && (!dout.valid || dout.ready);
  assign dig_idx = dig_left - CNT_W'(1);

  always_comb begin
    if (sign_p) begin
      emit_char = CHAR_MINUS;
      emit_last = 1'b0;
    end else if (dig_left != '0) begin
      emit_char = CHAR_ZERO + {4'd0, digits[dig_idx]};
      emit_last = (dig_left == CNT_W'(1)) && !space_p;
    end else begin
      emit_char = CHAR_SPACE;
      emit_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_p      <= 1'b0;
      space_p     <= 1'b0;
      dig_left    <= '0;
      dout.valid  <= 1'b0;
    end else begin
      if (load) begin
        sign_p   <= stg[NSTG].neg;
        space_p  <= stg[NSTG].sep;
        dig_left <= ndig_d;
      end else if (emit) begin
        if (sign_p) sign_p <= 1'b0;
        else if (dig_left != '0) dig_left <= dig_idx;
        else space_p <= 1'b0;
      end
      if (emit) dout.valid <= 1'b1;
      else if (dout.ready) dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) digits <= stg[NSTG].bcd;
    if (emit) begin
      dout.character <= emit_char;
      dout.last_char <= emit_last;
    end
  end

  // ---------------- checks ----------------
  `I32FMT_ASSERT_NXT(a_last_frees, emit && emit_last, !busy, "emitter busy after last beat")
  `I32FMT_ASSERT_NXT(a_load_busy, load, busy && dig_left != '0, "load gave no digits")
  `I32FMT_ASSERT_NOW(a_sign_digits, sign_p, dig_left != '0, "sign pending without digits")
  `I32FMT_ASSERT_NOW(a_dig_range, 1'b1, dig_left <= CNT_W'(NDIG), "digit count out of range")

endmodule
